@@ sv/dltq_pkg.sv @@
// Shared types and codes for the delta-list timer queue.
`default_nettype none
package dltq_pkg;
   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_INSERT     = 2'd1,
      OP_CANCEL_ID  = 2'd2,
      OP_CANCEL_KEY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_INSERTED  = 3'd0,
      KIND_EXPIRED   = 3'd1,
      KIND_CANCELLED = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_FULL      = 3'd4,
      KIND_QUIET     = 3'd5
   } kind_type;

   localparam int unsigned MAX_RESULTS = 32;
endpackage
`default_nettype wire

@@ sv/dltq_ram.sv @@
// Single-port entry storage with registered read data.
`default_nettype none
module dltq_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ sv/delta_list_timer_queue_unit.sv @@
// Delta-list timer queue: sequencer walking a linked list kept in entry RAMs.
//
// Channels: req_* carries one command (tick, insert, cancel by id or key);
// rsp_* returns result transfers, the final one of a command marked by
// rsp_last. An item transfers when valid is high and stall is low.
// One command is worked at a time; req_stall stays high until its last
// result transfers. Each list node is visited through address, read and
// compare states (S_RD, S_WAIT, S_EVAL), as the RAMs share one address port.
// Each result waits in the output register while rsp_stall is high; the
// sequencer goes on meanwhile and holds only when it has the next result.
// Reset is synchronous: a link-building pass then writes the free list,
// one entry per cycle over all ENTRIES entries, during which req_stall is high.
`default_nettype none
module delta_list_timer_queue_unit #(
   parameter int unsigned ENTRIES    = 32,
   parameter int unsigned DELAY_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_op,
   input  wire logic [31:0]  req_key,
   input  wire logic [15:0]  req_delay_ticks,
   input  wire logic [31:0]  req_cancel_id,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [31:0]       rsp_out_key,
   output logic [31:0]       rsp_out_id,
   output logic              rsp_last
);
   import dltq_pkg::*;

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned LW = AW + 1;               // link with null flag
   localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};
   localparam logic [DELAY_BITS-1:0] DMAX = '1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_RD     = 14'b00000000000100,  // issue read of cur
      S_WAIT   = 14'b00000000001000,  // data arriving
      S_EVAL   = 14'b00000000010000,
      S_WR     = 14'b00000000100000,  // not entered by any transition
      S_FRESH  = 14'b00000001000000,
      S_PREV   = 14'b00000010000000,
      S_NXRD   = 14'b00000100000000,
      S_NXWAIT = 14'b00001000000000,
      S_NXWR   = 14'b00010000000000,
      S_OUT    = 14'b00100000000000,
      S_FREE   = 14'b01000000000000,
      S_FRRD   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]             op_ff, op_in;
   logic [31:0]            key_ff, key_in, cid_ff, cid_in;
   logic [DELAY_BITS-1:0]  t_ff, t_in;
   logic [LW-1:0]          active_ff, active_in, free_ff, free_in;
   logic [LW-1:0]          cur_ff, cur_in, prev_ff, prev_in, fresh_ff, fresh_in;
   logic [LW-1:0]          nx_ff, nx_in;
   logic [DELAY_BITS-1:0]  cdelta_ff, cdelta_in;
   logic [31:0]            ckey_ff, ckey_in, cidv_ff, cidv_in;
   logic [31:0]            idc_ff, idc_in;
   logic [CW-1:0]          guard_ff, guard_in;
   logic [RW-1:0]          nres_ff, nres_in;
   logic                   dec_ff, dec_in;     // tick decrement done
   logic [3:0]             step_ff, step_in;   // sub-step within the S_FRRD and S_FREE sequences
   logic                   rv_ff, rv_in, rl_ff, rl_in;
   logic [2:0]             rk_ff, rk_in;
   logic [31:0]            rkey_ff, rkey_in, rid_ff, rid_in;

   // RAM port
   logic [AW-1:0]          addr;
   logic                   we_d, we_k, we_i, we_n;
   logic [DELAY_BITS-1:0]  wd_d, rd_d;
   logic [31:0]            wd_k, rd_k, wd_i, rd_i;
   logic [LW-1:0]          wd_n, rd_n;

   dltq_ram #(.DEPTH(ENTRIES), .WIDTH(DELAY_BITS)) u_delta (
      .clock(clock), .wr_en(we_d), .addr(addr), .wr_data(wd_d), .rd_data(rd_d));
   dltq_ram #(.DEPTH(ENTRIES), .WIDTH(32)) u_key (
      .clock(clock), .wr_en(we_k), .addr(addr), .wr_data(wd_k), .rd_data(rd_k));
   dltq_ram #(.DEPTH(ENTRIES), .WIDTH(32)) u_id (
      .clock(clock), .wr_en(we_i), .addr(addr), .wr_data(wd_i), .rd_data(rd_i));
   dltq_ram #(.DEPTH(ENTRIES), .WIDTH(LW)) u_next (
      .clock(clock), .wr_en(we_n), .addr(addr), .wr_data(wd_n), .rd_data(rd_n));

   assign req_stall   = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid   = rv_ff;
   assign rsp_kind    = rk_ff;
   assign rsp_out_key = rkey_ff;
   assign rsp_out_id  = rid_ff;
   assign rsp_last    = rl_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; key_in = key_ff; cid_in = cid_ff;
      t_in = t_ff; active_in = active_ff; free_in = free_ff; cur_in = cur_ff;
      prev_in = prev_ff; fresh_in = fresh_ff; nx_in = nx_ff;
      cdelta_in = cdelta_ff; ckey_in = ckey_ff; cidv_in = cidv_ff;
      idc_in = idc_ff; guard_in = guard_ff; nres_in = nres_ff; dec_in = dec_ff;
      step_in = step_ff; rv_in = rv_ff; rl_in = rl_ff; rk_in = rk_ff;
      rkey_in = rkey_ff; rid_in = rid_ff;
      addr = cur_ff[AW-1:0];
      we_d = 1'b0; we_k = 1'b0; we_i = 1'b0; we_n = 1'b0;
      wd_d = '0; wd_k = key_ff; wd_i = idc_ff; wd_n = NIL;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            addr = guard_ff[AW-1:0];
            we_n = 1'b1;
            wd_n = (guard_ff == CW'(ENTRIES - 1)) ? NIL : LW'(guard_ff + 1'b1);
            guard_in = guard_ff + 1'b1;
            if (guard_ff == CW'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               op_in = req_op; key_in = req_key; cid_in = req_cancel_id;
               t_in = (req_delay_ticks == 16'd0) ? DELAY_BITS'(1) :
                      ((32'(req_delay_ticks) > 32'(DMAX)) ? DMAX :
                       DELAY_BITS'(req_delay_ticks));
               cur_in = active_ff; prev_in = NIL; guard_in = '0;
               nres_in = '0; dec_in = 1'b0;
               if (req_op == OP_INSERT) begin
                  if (free_ff[AW]) begin
                     rv_in = 1'b1; rl_in = 1'b1; rk_in = KIND_FULL;
                     rkey_in = req_key; rid_in = '0;
                  end else begin
                     fresh_in = free_ff;
                     cur_in = free_ff; state_in = S_FRRD;
                     step_in = '0;
                  end
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_FRRD: begin
            // read next of fresh to pop the free list
            addr = fresh_ff[AW-1:0];
            if (step_ff == 4'd0) begin
               step_in = 4'd1;
            end else begin
               free_in = rd_n; cur_in = active_ff; state_in = S_RD;
            end
         end
         S_RD: begin
            if (cur_ff[AW] || (guard_ff == CW'(ENTRIES) && op_ff != OP_TICK)) begin
               state_in = S_EVAL;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cdelta_in = rd_d; ckey_in = rd_k; cidv_in = rd_i; nx_in = rd_n;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            step_in = '0;
            case (op_ff)
               OP_TICK: begin
                  if (!cur_ff[AW] && cdelta_ff == '0 && nres_ff != RW'(MAX_RESULTS)) begin
                     state_in = S_FREE;
                  end else if (!dec_ff && !cur_ff[AW] && cdelta_ff != '0) begin
                     addr = cur_ff[AW-1:0]; we_d = 1'b1;
                     wd_d = cdelta_ff - 1'b1; cdelta_in = cdelta_ff - 1'b1;
                     dec_in = 1'b1;
                  end else if (!dec_ff) begin
                     dec_in = 1'b1;
                  end else if (!rv_ff) begin
                     rv_in = 1'b1; rl_in = 1'b1;
                     if (nres_ff == '0) begin
                        rk_in = KIND_QUIET; rkey_in = '0; rid_in = '0;
                     end else begin
                        // last expiry result held back to carry the last flag
                        rk_in = KIND_EXPIRED; rkey_in = key_ff; rid_in = cid_ff;
                     end
                     state_in = S_IDLE;
                  end
               end
               OP_INSERT: begin
                  if (!cur_ff[AW] && guard_ff != CW'(ENTRIES) && cdelta_ff < t_ff) begin
                     t_in = t_ff - cdelta_ff;
                     prev_in = cur_ff; cur_in = nx_ff; guard_in = guard_ff + 1'b1;
                     state_in = S_RD;
                  end else begin
                     state_in = S_FRESH;
                  end
               end
               default: begin
                  if (cur_ff[AW] || guard_ff == CW'(ENTRIES)) begin
                     if (!rv_ff) begin
                        rv_in = 1'b1; rl_in = 1'b1; rk_in = KIND_NOT_FOUND;
                        rkey_in = (op_ff == OP_CANCEL_KEY) ? key_ff : '0;
                        rid_in  = (op_ff == OP_CANCEL_KEY) ? '0 : cid_ff;
                        state_in = S_IDLE;
                     end
                  end else if ((op_ff == OP_CANCEL_KEY) ? (ckey_ff == key_ff)
                                                        : (cidv_ff == cid_ff)) begin
                     state_in = S_FREE;
                  end else begin
                     prev_in = cur_ff; cur_in = nx_ff; guard_in = guard_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_FREE: begin
            // unlink cur: next gets delta added, prev/head relinked, cur freed
            case (step_ff)
               4'd0: begin
                  if (op_ff == OP_TICK && !rv_ff && nres_ff != '0) begin
                     // flush the held expiry result
                     rv_in = 1'b1; rl_in = 1'b0; rk_in = KIND_EXPIRED;
                     rkey_in = key_ff; rid_in = cid_ff;
                     step_in = 4'd1;
                  end else if (op_ff != OP_TICK || nres_ff == '0) begin
                     step_in = 4'd1;
                  end
               end
               4'd1: begin
                  if (nx_ff[AW]) begin
                     step_in = 4'd4;
                  end else begin
                     addr = nx_ff[AW-1:0]; step_in = 4'd2;
                  end
               end
               4'd2: begin
                  addr = nx_ff[AW-1:0]; step_in = 4'd3;
               end
               4'd3: begin
                  addr = nx_ff[AW-1:0]; we_d = 1'b1; wd_d = rd_d + cdelta_ff;
                  step_in = 4'd4;
               end
               4'd4: begin
                  if (prev_ff[AW]) begin
                     active_in = nx_ff;
                  end else begin
                     addr = prev_ff[AW-1:0]; we_n = 1'b1; wd_n = nx_ff;
                  end
                  step_in = 4'd5;
               end
               default: begin
                  addr = cur_ff[AW-1:0]; we_n = 1'b1; wd_n = free_ff;
                  free_in = cur_ff;
                  if (op_ff == OP_TICK) begin
                     key_in = ckey_ff; cid_in = cidv_ff;
                     nres_in = nres_ff + 1'b1;
                     cur_in = nx_ff;
                     state_in = S_RD;
                  end else if (!rv_ff || !rsp_stall) begin
                     rv_in = 1'b1; rl_in = 1'b1; rk_in = KIND_CANCELLED;
                     rkey_in = ckey_ff; rid_in = cidv_ff;
                     state_in = S_IDLE;
                  end else begin
                     free_in = free_ff;
                     we_n = 1'b0;
                  end
               end
            endcase
         end
         S_FRESH: begin
            addr = fresh_ff[AW-1:0];
            we_d = 1'b1; we_k = 1'b1; we_i = 1'b1; we_n = 1'b1;
            wd_d = t_ff; wd_k = key_ff; wd_i = idc_ff + 1'b1;
            wd_n = (cur_ff[AW] || guard_ff == CW'(ENTRIES)) ? NIL : cur_ff;
            if (guard_ff == CW'(ENTRIES)) begin
               cur_in = NIL;
            end
            idc_in = idc_ff + 1'b1;
            state_in = S_PREV;
         end
         S_PREV: begin
            if (prev_ff[AW]) begin
               active_in = fresh_ff;
            end else begin
               addr = prev_ff[AW-1:0]; we_n = 1'b1; wd_n = fresh_ff;
            end
            state_in = cur_ff[AW] ? S_OUT : S_NXWR;
         end
         S_NXWR: begin
            addr = cur_ff[AW-1:0]; we_d = 1'b1; wd_d = cdelta_ff - t_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rl_in = 1'b1; rk_in = KIND_INSERTED;
               rkey_in = key_ff; rid_in = idc_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; active_ff <= NIL; free_ff <= '0; idc_ff <= '0;
         guard_ff <= '0; rv_ff <= 1'b0; step_ff <= '0; nres_ff <= '0;
         dec_ff <= 1'b0;
      end else begin
         state_ff <= state_in; active_ff <= active_in; free_ff <= free_in;
         idc_ff <= idc_in; guard_ff <= guard_in; rv_ff <= rv_in;
         step_ff <= step_in; nres_ff <= nres_in; dec_ff <= dec_in;
      end
      op_ff <= op_in; key_ff <= key_in; cid_ff <= cid_in; t_ff <= t_in;
      cur_ff <= cur_in; prev_ff <= prev_in; fresh_ff <= fresh_in; nx_ff <= nx_in;
      cdelta_ff <= cdelta_in; ckey_ff <= ckey_in; cidv_ff <= cidv_in;
      rl_ff <= rl_in; rk_ff <= rk_in; rkey_ff <= rkey_in; rid_ff <= rid_in;
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rk_ff) && $stable(rid_ff)))
      else $error("stalled result changed");
   a_ids_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRESH) |=> (idc_ff == $past(idc_ff) + 32'd1))
      else $error("id counter slip");
`endif
endmodule
`default_nettype wire
